// ===== src/mpeg_audio_frame_header_parser_assert.svh =====
// Assertion macros used by the frame header parser checker.
// No dependencies; included by the checker file.
`ifndef MPEG_AUDIO_FRAME_HEADER_PARSER_ASSERT_SVH
`define MPEG_AUDIO_FRAME_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define MAHP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("mahp: same-cycle check failed");

// next-cycle implication
`define MAHP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("mahp: next-cycle check failed");

`endif

// ===== src/mahp_pkg.sv =====
// Types, header codes and lookup tables for the MPEG audio frame header parser.
// No dependencies.
package mahp_pkg;

	typedef struct packed {
		logic [31:0] header_word;
		logic        header_complete;
	} header_t;

	typedef struct packed {
		logic        header_ok;
		logic [11:0] frame_len;
		logic [10:0] frame_samples;
		logic [15:0] sample_rate_hz;
		logic [1:0]  channel_count;
		logic [8:0]  kbit_rate;
		logic [1:0]  layer_number;
		logic [1:0]  version_code;
	} frame_info_t;

	localparam int RECIP_SHIFT = 36;
	localparam int RECIP_W     = 24;
	localparam int NUM_W       = 27;
	localparam int QUO_W       = 12;
	localparam int PROD_W      = 28;

	typedef struct packed {
		logic               ok;
		logic [1:0]         layer;
		logic [1:0]         version;
		logic [15:0]        rate;
		logic [RECIP_W-1:0] recip;
		logic [8:0]         bitrate;
		logic [10:0]        samples;
		logic [1:0]         channels;
		logic               pad;
		logic [17:0]        kmul;
	} dec_t;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] SYNC_MASK = 8'hE0;

	localparam logic [1:0] VBITS_V25      = 2'b00;
	localparam logic [1:0] VBITS_RESERVED = 2'b01;
	localparam logic [1:0] VBITS_V2       = 2'b10;
	localparam logic [1:0] VBITS_V1       = 2'b11;
	localparam logic [1:0] LBITS_RESERVED = 2'b00;
	localparam logic [1:0] RI_RESERVED    = 2'b11;
	localparam logic [3:0] BRI_FREE       = 4'd0;
	localparam logic [3:0] BRI_BAD        = 4'd15;
	localparam logic [1:0] MODE_MONO      = 2'b11;

	localparam logic [1:0] VER_MPEG1  = 2'd1;
	localparam logic [1:0] VER_MPEG2  = 2'd2;
	localparam logic [1:0] VER_MPEG25 = 2'd3;
	localparam logic [1:0] LAYER_I    = 2'd1;
	localparam logic [1:0] LAYER_III  = 2'd3;
	localparam logic [1:0] CH_MONO    = 2'd1;
	localparam logic [1:0] CH_STEREO  = 2'd2;

	localparam logic [10:0] SAMPLES_L1    = 11'd384;
	localparam logic [10:0] SAMPLES_SHORT = 11'd576;
	localparam logic [10:0] SAMPLES_LONG  = 11'd1152;
	localparam logic [17:0] K_L1    = 18'd12000;
	localparam logic [17:0] K_SHORT = 18'(576 / 8 * 1000);
	localparam logic [17:0] K_LONG  = 18'(1152 / 8 * 1000);
	localparam logic [11:0] HDR_BYTES = 12'd4;

	// [version bits][rate index]
	localparam logic [15:0] RATE_TAB [4][4] = '{
		'{16'd11025, 16'd12000, 16'd8000,  16'd0},
		'{16'd0,     16'd0,     16'd0,     16'd0},
		'{16'd22050, 16'd24000, 16'd16000, 16'd0},
		'{16'd44100, 16'd48000, 16'd32000, 16'd0}
	};

	// floor(2^RECIP_SHIFT / rate)
	localparam logic [RECIP_W-1:0] RECIP_TAB [4][4] = '{
		'{RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd11025),
		  RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd12000),
		  RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd8000), '0},
		'{'0, '0, '0, '0},
		'{RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd22050),
		  RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd24000),
		  RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd16000), '0},
		'{RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd44100),
		  RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd48000),
		  RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd32000), '0}
	};

	// rows by layer bits: reserved, layer III, layer II, layer I
	localparam logic [8:0] BR_V1 [4][16] = '{
		'{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
		  9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
		'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
		  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
	};

	localparam logic [8:0] BR_V2 [4][16] = '{
		'{9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0,
		  9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
		'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
		  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
		'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
		  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
	};

endpackage

// ===== src/mahp_fifo.sv =====
// Small register-based queue, first-word fall-through.
// No package dependencies.
module mahp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/mahp_front.sv =====
// Front end: sync check, rejection of reserved codes and free or bad bitrate indices, and table lookups.
// Depends on mahp_pkg.
module mahp_front (
	input  mahp_pkg::header_t header,
	output mahp_pkg::dec_t    dec
);
	import mahp_pkg::*;

	logic [7:0] b0, b1, b2, b3;
	logic [1:0] vbits, lbits, ri, mode;
	logic [3:0] bri;
	logic       v1;
	logic [1:0] layer;
	logic       pre_ok;

	assign b0    = header.header_word[31:24];
	assign b1    = header.header_word[23:16];
	assign b2    = header.header_word[15:8];
	assign b3    = header.header_word[7:0];
	assign vbits = b1[4:3];
	assign lbits = b1[2:1];
	assign bri   = b2[7:4];
	assign ri    = b2[3:2];
	assign mode  = b3[7:6];
	assign v1    = (vbits == VBITS_V1);
	assign layer = 2'(3'd4 - {1'b0, lbits});

	assign pre_ok = header.header_complete && (b0 == SYNC_BYTE)
		&& ((b1 & SYNC_MASK) == SYNC_MASK) && (vbits != VBITS_RESERVED)
		&& (lbits != LBITS_RESERVED) && (ri != RI_RESERVED)
		&& (bri != BRI_FREE) && (bri != BRI_BAD);

	always_comb begin
		dec = '0;
		if (pre_ok) begin
			dec.ok       = 1'b1;
			dec.layer    = layer;
			dec.rate     = RATE_TAB[vbits][ri];
			dec.recip    = RECIP_TAB[vbits][ri];
			dec.bitrate  = v1 ? BR_V1[lbits][bri] : BR_V2[lbits][bri];
			dec.pad      = b2[1];
			dec.channels = (mode == MODE_MONO) ? CH_MONO : CH_STEREO;
			if (v1) begin
				dec.version = VER_MPEG1;
			end else if (vbits == VBITS_V2) begin
				dec.version = VER_MPEG2;
			end else begin
				dec.version = VER_MPEG25;
			end
			if (layer == LAYER_I) begin
				dec.samples = SAMPLES_L1;
				dec.kmul    = K_L1;
			end else if (layer == LAYER_III && !v1) begin
				dec.samples = SAMPLES_SHORT;
				dec.kmul    = K_SHORT;
			end else begin
				dec.samples = SAMPLES_LONG;
				dec.kmul    = K_LONG;
			end
		end
	end

endmodule

// ===== src/mahp_back.sv =====
// Back end: frame length pipeline (multiply, reciprocal divide, correct, pad).
// Issues from the decoded-item queue against credit for the result queue.
// Depends on mahp_pkg.
module mahp_back #(
	parameter int OUT_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  mahp_pkg::dec_t        q_data,
	output logic                  q_pop,
	output logic                  res_valid,
	output mahp_pkg::frame_info_t res,
	input  logic                  pop_done
);
	import mahp_pkg::*;

	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [CW-1:0] credit_q;
	logic          issue;

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	dec_t              dec_s1, dec_s2, dec_s3, dec_s4;
	logic [NUM_W-1:0]  n_s1, n_s2, n_s3;
	logic [QUO_W-1:0]  q_s2, q_s3, qf_s4;
	logic [PROD_W-1:0] p_s3;

	logic [NUM_W+RECIP_W-1:0] recip_prod;
	logic [PROD_W-1:0]        rem;
	logic [QUO_W-1:0]         base;
	logic [11:0]              bytes;

	assign issue = !q_empty && (credit_q < CW'(OUT_DEPTH));
	assign q_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			case ({issue, pop_done})
				2'b10:   credit_q <= credit_q + CW'(1);
				2'b01:   credit_q <= credit_q - CW'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	assign recip_prod = (NUM_W+RECIP_W)'(n_s1) * (NUM_W+RECIP_W)'(dec_s1.recip);
	assign rem        = PROD_W'(n_s3) - p_s3;

	always_ff @(posedge clk) begin
		dec_s1 <= q_data;
		n_s1   <= NUM_W'(q_data.kmul) * NUM_W'(q_data.bitrate);

		dec_s2 <= dec_s1;
		n_s2   <= n_s1;
		q_s2   <= recip_prod[RECIP_SHIFT +: QUO_W];

		dec_s3 <= dec_s2;
		n_s3   <= n_s2;
		q_s3   <= q_s2;
		p_s3   <= PROD_W'(q_s2) * PROD_W'(dec_s2.rate);

		dec_s4 <= dec_s3;
		qf_s4  <= q_s3 + QUO_W'(rem >= PROD_W'(dec_s3.rate));
	end

	assign base  = qf_s4 + QUO_W'(dec_s4.pad);
	assign bytes = (dec_s4.layer == LAYER_I) ? {base[9:0], 2'b00} : base;

	assign res_valid = vld_s4;

	always_comb begin
		res = '0;
		if (dec_s4.ok && (bytes > HDR_BYTES)) begin
			res.header_ok      = 1'b1;
			res.frame_len      = bytes;
			res.frame_samples  = dec_s4.samples;
			res.sample_rate_hz = dec_s4.rate;
			res.channel_count  = dec_s4.channels;
			res.kbit_rate      = dec_s4.bitrate;
			res.layer_number   = dec_s4.layer;
			res.version_code   = dec_s4.version;
		end
	end

endmodule

// ===== src/mpeg_audio_frame_header_parser.sv =====
// A pushed header goes through the middle queue, stages s1 to s4 and the result queue.
// Throughput: one header per cycle, sustained while results are popped each cycle; the
// four-stage length pipeline issues only against free room in the OUT_DEPTH result queue.
// Reset (arst_n low, asynchronous) empties both queues and the pipeline; any queued or
// in-flight result is discarded.
module mpeg_audio_frame_header_parser #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  mahp_pkg::header_t     header,
	output logic                  empty,
	input  logic                  pop,
	output mahp_pkg::frame_info_t frame_info
);
	import mahp_pkg::*;

	dec_t        dec;
	dec_t        mid_data;
	logic        mid_empty;
	logic        mid_pop;
	logic        res_valid;
	frame_info_t res;
	logic        pop_done;

	assign pop_done = pop && !empty;

	mahp_front u_front (
		.header (header),
		.dec    (dec)
	);

	mahp_fifo #(
		.WIDTH ($bits(dec_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (dec),
		.full    (full),
		.rd_en   (mid_pop),
		.rd_data (mid_data),
		.empty   (mid_empty)
	);

	mahp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (mid_empty),
		.q_data    (mid_data),
		.q_pop     (mid_pop),
		.res_valid (res_valid),
		.res       (res),
		.pop_done  (pop_done)
	);

	mahp_fifo #(
		.WIDTH ($bits(frame_info_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (),
		.rd_en   (pop),
		.rd_data (frame_info),
		.empty   (empty)
	);

endmodule

// ===== src/mahp_checker.sv =====
// Port-level checks for the frame header parser, bound to the top level.
// Depends on mahp_pkg and mpeg_audio_frame_header_parser_assert.svh.
`include "mpeg_audio_frame_header_parser_assert.svh"

module mahp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input mahp_pkg::frame_info_t frame_info
);
	import mahp_pkg::*;

	logic [15:0] outstanding_q;
	logic        rej_now;
	logic        ok_now;
	logic        rest_zero;
	logic        fields_set;
	logic        l1_now;
	logic        l1_shape;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({push && !full, pop && !empty})
				2'b10:   outstanding_q <= outstanding_q + 16'd1;
				2'b01:   outstanding_q <= outstanding_q - 16'd1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	assign rej_now = !empty && !frame_info.header_ok;
	assign ok_now  = !empty && frame_info.header_ok;
	assign l1_now  = ok_now && (frame_info.layer_number == LAYER_I);

	assign rest_zero = (frame_info.frame_len == '0) && (frame_info.frame_samples == '0)
		&& (frame_info.sample_rate_hz == '0) && (frame_info.channel_count == '0)
		&& (frame_info.kbit_rate == '0) && (frame_info.layer_number == '0)
		&& (frame_info.version_code == '0);

	assign fields_set = (frame_info.frame_len > HDR_BYTES) && (frame_info.sample_rate_hz != '0)
		&& (frame_info.kbit_rate != '0) && (frame_info.channel_count != '0)
		&& (frame_info.layer_number != '0) && (frame_info.version_code != '0);

	assign l1_shape = (frame_info.frame_samples == SAMPLES_L1)
		&& (frame_info.frame_len[1:0] == 2'b00);

	`MAHP_ASSERT_IMP(a_no_orphan, clk, arst_n, !empty, outstanding_q != 16'd0)
	`MAHP_ASSERT_IMP(a_reject_zero, clk, arst_n, rej_now, rest_zero)
	`MAHP_ASSERT_IMP(a_ok_fields, clk, arst_n, ok_now, fields_set)
	`MAHP_ASSERT_IMP(a_layer1_len, clk, arst_n, l1_now, l1_shape)
	`MAHP_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(frame_info))

endmodule

bind mpeg_audio_frame_header_parser mahp_checker u_mahp_checker (.*);
